// ===== rtl/core/shist_pkg.sv =====
// Shared types and constants for the symbol histogram engine.
// Used by shist_ctrl and symbol_histogram_engine; no dependencies.
package shist_pkg;

    localparam int CFG_W    = 11;
    localparam int SYM_W    = 16;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0]   CFG_RESET = 11'd1024;
    localparam logic [VALUE_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef enum logic {
        OP_COUNT = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_result;

endpackage

// ===== rtl/core/shist_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
module shist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/shist_ctrl.sv =====
// Bin update sequencer: clearing sweep after reset, then read-modify-write of
// one bin per word. Depends on shist_pkg; drives the ports of one shist_ram.
module shist_ctrl
    import shist_pkg::*;
#(
    parameter int MAX_BINS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  t_op                         i_op,
    input  logic [SYM_W-1:0]            i_symbol,
    input  logic                        i_clear,
    input  logic [CFG_W-1:0]            i_bin_limit,
    input  logic                        i_out_busy,
    output logic                        o_res_valid,
    output t_result                     o_res,
    output logic                        o_ram_wr_en,
    output logic [$clog2(MAX_BINS)-1:0] o_ram_wr_addr,
    output logic [VALUE_W-1:0]          o_ram_wr_data,
    output logic                        o_ram_rd_en,
    output logic [$clog2(MAX_BINS)-1:0] o_ram_rd_addr,
    input  logic [VALUE_W-1:0]          i_ram_rd_data
);

    localparam int AW = $clog2(MAX_BINS);
    localparam logic [SYM_W:0]  BIN_CAP  = (SYM_W+1)'(MAX_BINS);
    localparam logic [AW-1:0]   LAST_BIN = AW'(MAX_BINS - 1);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    t_op             r_op;
    logic            r_clear;
    logic            r_range;
    logic [AW-1:0]   r_addr;

    logic            accept;
    logic            sym_range;

    assign accept    = (r_state == S_IDLE) && i_in_valid;
    assign sym_range = ({1'b0, i_symbol} >= (SYM_W+1)'(i_bin_limit))
                     || ({1'b0, i_symbol} >= BIN_CAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Item payload, captured on accept and held through the update state
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_clear <= i_clear;
            r_range <= sym_range;
            r_addr  <= i_symbol[AW-1:0];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        o_in_ready    = 1'b0;
        o_res_valid   = 1'b0;
        o_res.value   = '0;
        o_res.status  = ST_OK;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = r_addr;
        o_ram_wr_data = '0;
        o_ram_rd_en   = accept;
        o_ram_rd_addr = i_symbol[AW-1:0];

        case (r_state)
            S_CLEAR: begin
                // Zero one bin a cycle
                o_ram_wr_en   = 1'b1;
                o_ram_wr_addr = r_clr_addr;
                n_clr_addr    = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_BIN) begin
                    n_clr_addr = '0;
                    n_state    = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_range) begin
                    o_res.status = ST_RANGE;
                end else if (r_op == OP_COUNT) begin
                    if (i_ram_rd_data == COUNT_MAX) begin
                        o_res.value  = COUNT_MAX;
                        o_res.status = ST_SAT;
                    end else begin
                        o_res.value   = i_ram_rd_data + 1'b1;
                        o_ram_wr_data = i_ram_rd_data + 1'b1;
                        o_ram_wr_en   = !i_out_busy;
                    end
                end else begin
                    o_res.value = i_ram_rd_data;
                    o_ram_wr_en = r_clear && !i_out_busy;
                end
                // Hold while the output register is still full
                if (!i_out_busy) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/symbol_histogram_engine.sv =====
// Symbol histogram engine: MAX_BINS saturating 32-bit bins in one RAM.
// An accepted word is handled in S_UPDATE: its bin, read through the single RAM
// port pair, is written back where needed and the result goes to the output
// register. No new word is taken before that; the output register decouples backpressure.
// Reset (synchronous, active low): bin_count_in_use returns to 1024, then a
// clearing sweep zeroes all MAX_BINS bins with s_axis_tready low.
module symbol_histogram_engine
    import shist_pkg::*;
#(
    parameter int MAX_BINS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: bin_count_in_use
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,  // [15:0] symbol, [16] clear_after_read, rest zero
    input  logic [0:0]        s_axis_tuser,  // [0] operation
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // [31:0] bin_value
    output logic [1:0]        m_axis_tuser   // [1:0] status
);

    localparam int AW = $clog2(MAX_BINS);

    logic [CFG_W-1:0]   r_cfg;
    logic               r_out_valid;
    t_result            r_out;

    logic               out_busy;
    logic               res_valid;
    t_result            res;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    assign out_busy = r_out_valid && !m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    shist_ctrl #(
        .MAX_BINS (MAX_BINS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_op          (t_op'(s_axis_tuser[0])),
        .i_symbol      (s_axis_tdata[SYM_W-1:0]),
        .i_clear       (s_axis_tdata[SYM_W]),
        .i_bin_limit   (r_cfg),
        .i_out_busy    (out_busy),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

    shist_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = r_out.status;

endmodule
